[rtl/skt_pkg.sv]
// Package with the types, codes and default sizes of the sorted key table.
package skt_pkg;

  localparam int unsigned DEF_TABLE_DEPTH = 64;
  localparam int unsigned DEF_KEY_BYTES   = 8;

  localparam int unsigned KEY_FIELD_W = 64;
  localparam int unsigned OWNER_W     = 31;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned OCC_W       = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2,
    OP_UPDATE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_DUPLICATE = 2'd2,
    STS_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_COMPARE = 2'd1,
    ST_DECODE  = 2'd2,
    ST_EXECUTE = 2'd3
  } ctrl_state_e;

  typedef struct packed {
    op_e                    opcode;
    logic [KEY_FIELD_W-1:0] key;
    logic [OWNER_W-1:0]     owner_id;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [POS_W-1:0]   position;
    logic [OWNER_W-1:0] found_owner;
    logic [OCC_W-1:0]   occupancy;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic compare;
    logic decode;
    logic execute;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } dpath_sts_t;

endpackage

[rtl/sorted_key_table_core.sv]
// Top level of the sorted key table: controller, datapath and checks.
//
// Requests arrive on the in channel (in_valid_i, in_stall_o, in_req_i) and one
// response per request leaves on the out channel (out_valid_o, out_stall_i,
// out_rsp_o). A transfer happens on a rising edge with valid high and stall low.
// Each request passes through four steps: one takes the transfer, one compares
// every table cell against the key at once, one encodes the sorted position
// and selects the payload, and one shifts or writes the cells and loads the
// response register. The response is visible the cycle after that. The block
// takes no new request until the last step of the one before is done.
// The response register lets the next request be taken while a response waits;
// if the receiver still stalls when the following response is ready, the block
// holds in its last step and keeps in_stall_o high until the register frees.
// Reset empties the table and the response register at once; no clearing pass
// is needed, as cells beyond the entry count are never read.
module sorted_key_table_core
  import skt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned KEY_BYTES   = DEF_KEY_BYTES
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  ctrl_cmd_t  cmd;
  dpath_sts_t sts;

  skt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  skt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BYTES   (KEY_BYTES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block took a request without going busy");

  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status == STS_FULL) |->
      (out_rsp_o.position == '0 && out_rsp_o.found_owner == '0))
    else $error("full response carries a position or payload");

  a_not_found_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status == STS_NOT_FOUND) |->
      (out_rsp_o.position == '0 && out_rsp_o.found_owner == '0))
    else $error("not found response carries a position or payload");

  a_one_transfer_per_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.execute) |-> (!out_valid_o || !out_stall_i))
    else $error("response register overwritten while stalled");

endmodule

[rtl/skt_ctrl.sv]
// Controller state machine that steps each request through compare, decode and execute.
module skt_ctrl
  import skt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  dpath_sts_t sts_i,
  output logic       in_stall_o,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        state_d = ST_DECODE;
      end
      ST_DECODE: begin
        state_d = ST_EXECUTE;
      end
      ST_EXECUTE: begin
        if (!sts_i.out_blocked) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    in_stall_o    = (state_q != ST_IDLE);
    cmd_o.capture = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.compare = (state_q == ST_COMPARE);
    cmd_o.decode  = (state_q == ST_DECODE);
    cmd_o.execute = (state_q == ST_EXECUTE) && !sts_i.out_blocked;
  end

endmodule

[rtl/skt_dpath.sv]
// Datapath with the row of table cells, their comparators, the position encoder and the result register.
module skt_dpath
  import skt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned KEY_BYTES   = DEF_KEY_BYTES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  output dpath_sts_t sts_o,
  input  req_t       in_req_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output rsp_t       out_rsp_o
);

  localparam int unsigned KEY_W = KEY_BYTES * 8;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  logic [KEY_W-1:0]   key_q   [TABLE_DEPTH];
  logic [OWNER_W-1:0] owner_q [TABLE_DEPTH];
  logic [CNT_W-1:0]   count_q, count_d;

  op_e                op_q;
  logic [KEY_W-1:0]   rkey_q;
  logic [OWNER_W-1:0] rown_q;

  logic [TABLE_DEPTH-1:0] lt_q, lt_d, eq_q, eq_d, bnd;
  logic [IDX_W-1:0]       pos_q, pos_d;
  logic                   hit_q;
  logic [OWNER_W-1:0]     hit_owner_q, hit_owner_d;

  logic out_valid_q;
  rsp_t out_rsp_q, out_rsp_d;

  logic full, ins_ok, del_ok, upd_ok;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= in_req_i.opcode;
      rkey_q <= in_req_i.key[KEY_W-1:0];
      rown_q <= in_req_i.owner_id;
    end
  end

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      lt_d[i] = (CNT_W'(i) < count_q) && (key_q[i] < rkey_q);
      eq_d[i] = (CNT_W'(i) < count_q) && (key_q[i] == rkey_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.compare) begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
  end

  always_comb begin
    bnd[0] = !lt_q[0];
    for (int i = 1; i < TABLE_DEPTH; i++) begin
      bnd[i] = lt_q[i-1] && !lt_q[i];
    end
  end

  always_comb begin
    pos_d       = '0;
    hit_owner_d = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (bnd[i]) begin
        pos_d = pos_d | IDX_W'(i);
      end
      if (eq_q[i]) begin
        hit_owner_d = hit_owner_d | owner_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      pos_q       <= pos_d;
      hit_q       <= |eq_q;
      hit_owner_q <= hit_owner_d;
    end
  end

  assign full   = (count_q == CNT_W'(TABLE_DEPTH));
  assign ins_ok = (op_q == OP_INSERT) && !hit_q && !full;
  assign del_ok = (op_q == OP_DELETE) && hit_q;
  assign upd_ok = (op_q == OP_UPDATE) && hit_q;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic [KEY_W-1:0]   up_key, dn_key, key_d;
    logic [OWNER_W-1:0] up_own, dn_own, own_d;
    logic               shift_up, shift_dn;

    if (g > 0) begin : g_up
      assign up_key   = key_q[g-1];
      assign up_own   = owner_q[g-1];
      assign shift_up = !lt_q[g-1];
    end else begin : g_no_up
      assign up_key   = key_q[g];
      assign up_own   = owner_q[g];
      assign shift_up = 1'b0;
    end

    if (g < TABLE_DEPTH - 1) begin : g_dn
      assign dn_key   = key_q[g+1];
      assign dn_own   = owner_q[g+1];
      assign shift_dn = !lt_q[g];
    end else begin : g_no_dn
      assign dn_key   = key_q[g];
      assign dn_own   = owner_q[g];
      assign shift_dn = 1'b0;
    end

    always_comb begin
      key_d = key_q[g];
      own_d = owner_q[g];
      if (cmd_i.execute) begin
        priority if (ins_ok) begin
          if (shift_up) begin
            key_d = up_key;
            own_d = up_own;
          end else if (!lt_q[g]) begin
            key_d = rkey_q;
            own_d = rown_q;
          end
        end else if (del_ok) begin
          if (shift_dn) begin
            key_d = dn_key;
            own_d = dn_own;
          end
        end else if (upd_ok && eq_q[g]) begin
          own_d = rown_q;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      key_q[g]   <= key_d;
      owner_q[g] <= own_d;
    end
  end

  always_comb begin
    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + CNT_W'(1);
    end else if (del_ok) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.execute) begin
      count_q <= count_d;
    end
  end

  always_comb begin
    logic [31:0] pos_ext;
    logic [31:0] occ_ext;
    pos_ext = 32'(pos_q);
    occ_ext = 32'(count_d);
    out_rsp_d.status      = STS_OK;
    out_rsp_d.position    = '0;
    out_rsp_d.found_owner = '0;
    out_rsp_d.occupancy   = occ_ext[OCC_W-1:0];
    if (op_q == OP_INSERT) begin
      priority if (hit_q) begin
        out_rsp_d.status   = STS_DUPLICATE;
        out_rsp_d.position = pos_ext[POS_W-1:0];
      end else if (full) begin
        out_rsp_d.status = STS_FULL;
      end else begin
        out_rsp_d.position = pos_ext[POS_W-1:0];
      end
    end else if (!hit_q) begin
      out_rsp_d.status = STS_NOT_FOUND;
    end else begin
      out_rsp_d.position = pos_ext[POS_W-1:0];
      if (op_q == OP_LOOKUP) begin
        out_rsp_d.found_owner = hit_owner_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.execute) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      out_rsp_q <= out_rsp_d;
    end
  end

  assign sts_o.out_blocked = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_rsp_o         = out_rsp_q;

endmodule

[tb/tb_sorted_key_table_core.sv]
// Self-checking testbench for the sorted key table: directed rows, then shaped random traffic.
module tb_sorted_key_table_core;
  import skt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH      = DEF_TABLE_DEPTH;
  localparam int unsigned KBYTES     = DEF_KEY_BYTES;
  localparam logic [63:0] KEY_MASK   = {64{1'b1}} >> (64 - 8 * KBYTES);
  localparam logic [63:0] KEY_TOP    = {64{1'b1}};
  localparam int          CLK_HALF   = 4;
  localparam int          N_RANDOM   = 1330;
  localparam int          POOL_N     = 32;
  localparam int          HOLD_CYC   = 90;
  localparam int          CYC_LIMIT  = 200000;
  localparam int          QUIET_LO   = 450;
  localparam int          QUIET_HI   = 650;
  localparam int          HOLD_AT    = 800;

  typedef struct packed {
    op_e                opcode;
    logic [63:0]        key;
    logic [OWNER_W-1:0] owner;
    logic               typed;
    rsp_t               rsp;
  } dir_row_t;

  typedef struct packed {
    logic typed;
    rsp_t rsp;
  } typed_rsp_t;

  localparam int N_DIR = 21;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{OP_LOOKUP, 64'h0, 31'h0, 1'b1, '{STS_NOT_FOUND, 6'd0, 31'd0, 7'd0}},
    '{OP_DELETE, KEY_TOP, 31'h0, 1'b1, '{STS_NOT_FOUND, 6'd0, 31'd0, 7'd0}},
    '{OP_UPDATE, 64'h0, 31'h5, 1'b1, '{STS_NOT_FOUND, 6'd0, 31'd0, 7'd0}},
    '{OP_INSERT, KEY_TOP, 31'h7FFF_FFFF, 1'b1, '{STS_OK, 6'd0, 31'd0, 7'd1}},
    '{OP_INSERT, 64'h0, 31'h0, 1'b1, '{STS_OK, 6'd0, 31'd0, 7'd2}},
    '{OP_LOOKUP, KEY_TOP, 31'h0, 1'b1, '{STS_OK, 6'd1, 31'h7FFF_FFFF, 7'd2}},
    '{OP_INSERT, KEY_TOP, 31'h1, 1'b1, '{STS_DUPLICATE, 6'd1, 31'd0, 7'd2}},
    '{OP_INSERT, 64'h8000_0000_0000_0000, 31'h2AAA_AAAA, 1'b0, '0},
    '{OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 31'h5555_5555, 1'b0, '0},
    '{OP_INSERT, 64'h1, 31'h1, 1'b0, '0},
    '{OP_LOOKUP, 64'h8000_0000_0000_0000, 31'h0, 1'b0, '0},
    '{OP_UPDATE, 64'h0, 31'h7FFF_FFFF, 1'b0, '0},
    '{OP_LOOKUP, 64'h0, 31'h0, 1'b0, '0},
    '{OP_DELETE, 64'h0, 31'h0, 1'b0, '0},
    '{OP_DELETE, KEY_TOP, 31'h0, 1'b0, '0},
    '{OP_DELETE, KEY_TOP, 31'h0, 1'b1, '{STS_NOT_FOUND, 6'd0, 31'd0, 7'd3}},
    '{OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, 31'h0, 1'b1, '{STS_NOT_FOUND, 6'd0, 31'd0, 7'd3}},
    '{OP_UPDATE, 64'h7FFF_FFFF_FFFF_FFFF, 31'h0, 1'b0, '0},
    '{OP_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 31'h0, 1'b0, '0},
    '{OP_LOOKUP, 64'h1, 31'h7FFF_FFFF, 1'b0, '0},
    '{OP_DELETE, 64'h1, 31'h0, 1'b0, '0}
  };

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  req_t in_req_i    = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_rsp_o;

  logic [63:0]        table_keys   [DEPTH];
  logic [OWNER_W-1:0] table_owners [DEPTH];
  int unsigned        table_count  = 0;
  logic [63:0]        key_pool     [POOL_N];

  rsp_t       rsp_due_q   [$];
  typed_rsp_t typed_rsp_q [$];

  int  offered_n  = 0;
  int  checked_n  = 0;
  int  fail_n     = 0;
  int  peak_count = 0;
  int  cycles     = 0;
  int  status_seen [4] = '{0, 0, 0, 0};
  logic quiet;

  assign quiet = (offered_n >= QUIET_LO) && (offered_n < QUIET_HI);

  sorted_key_table_core #(
    .TABLE_DEPTH(DEPTH),
    .KEY_BYTES  (KBYTES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  function automatic rsp_t apply_table_request(input req_t r);
    rsp_t        o;
    logic [63:0] k;
    int          hit;
    int unsigned p;
    o   = '0;
    o.status = STS_OK;
    k   = r.key & KEY_MASK;
    hit = -1;
    p   = 0;
    for (int i = 0; i < int'(table_count); i++) begin
      if (hit < 0 && table_keys[i] == k) hit = i;
    end
    if (r.opcode == OP_INSERT) begin
      if (hit >= 0) begin
        o.status = STS_DUPLICATE;
        p = unsigned'(hit);
      end else if (table_count >= DEPTH) begin
        o.status = STS_FULL;
      end else begin
        while (p < table_count && table_keys[p] < k) p++;
        for (int unsigned i = table_count; i > p; i--) begin
          table_keys[i]   = table_keys[i-1];
          table_owners[i] = table_owners[i-1];
        end
        table_keys[p]   = k;
        table_owners[p] = r.owner_id;
        table_count++;
      end
    end else if (hit < 0) begin
      o.status = STS_NOT_FOUND;
    end else begin
      p = unsigned'(hit);
      case (r.opcode)
        OP_LOOKUP: o.found_owner = table_owners[p];
        OP_DELETE: begin
          for (int unsigned i = p + 1; i < table_count; i++) begin
            table_keys[i-1]   = table_keys[i];
            table_owners[i-1] = table_owners[i];
          end
          table_count--;
        end
        default: table_owners[p] = r.owner_id;
      endcase
    end
    o.position  = p[POS_W-1:0];
    o.occupancy = table_count[OCC_W-1:0];
    return o;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_n++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    rsp_t       want;
    rsp_t       model;
    typed_rsp_t note;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        checked_n++;
        if (rsp_due_q.size() == 0) begin
          $error("response with no request outstanding: %h", out_rsp_o);
          fail_n++;
        end else begin
          want = rsp_due_q.pop_front();
          check_field("status", 64'(want.status), 64'(out_rsp_o.status));
          check_field("position", 64'(want.position), 64'(out_rsp_o.position));
          check_field("found_owner", 64'(want.found_owner), 64'(out_rsp_o.found_owner));
          check_field("occupancy", 64'(want.occupancy), 64'(out_rsp_o.occupancy));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        note  = typed_rsp_q.pop_front();
        model = apply_table_request(in_req_i);
        status_seen[model.status]++;
        if (int'(table_count) > peak_count) peak_count = int'(table_count);
        rsp_due_q.push_back(note.typed ? note.rsp : model);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYC_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : receiver
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && offered_n >= HOLD_AT) begin
        held = 1'b1;
        repeat (HOLD_CYC) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < 28);
      end
    end
  end

  task automatic offer_request(input req_t r, input logic typed, input rsp_t rsp);
    typed_rsp_q.push_back('{typed, rsp});
    while (!quiet && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    offered_n++;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic req_t pick_request(input int mode);
    req_t r;
    int   roll;
    int   hit_pct;
    roll = $urandom_range(99);
    case (mode)
      0: r.opcode = roll < 75 ? OP_INSERT : roll < 85 ? OP_LOOKUP :
                    roll < 95 ? OP_UPDATE : OP_DELETE;
      1: r.opcode = op_e'($urandom_range(3));
      default: r.opcode = roll < 60 ? OP_DELETE : roll < 75 ? OP_LOOKUP :
                          roll < 88 ? OP_UPDATE : OP_INSERT;
    endcase
    r.owner_id = OWNER_W'($urandom);
    hit_pct = (r.opcode == OP_INSERT) ? 10 : 70;
    if (table_count != 0 && $urandom_range(99) < hit_pct) begin
      r.key = table_keys[$urandom_range(table_count - 1)];
    end else if ($urandom_range(1) == 1) begin
      r.key = {$urandom, $urandom};
    end else begin
      r.key = key_pool[$urandom_range(POOL_N - 1)];
    end
    return r;
  endfunction

  initial begin : stimulus
    req_t r;
    key_pool[0] = 64'h0;
    key_pool[1] = KEY_TOP;
    key_pool[2] = 64'h1;
    key_pool[3] = KEY_TOP - 64'h1;
    key_pool[4] = 64'h5555_5555_5555_5555;
    key_pool[5] = 64'hAAAA_AAAA_AAAA_AAAA;
    for (int i = 6; i < POOL_N; i++) key_pool[i] = {$urandom, $urandom};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIR; i++) begin
      r.opcode   = DIR_ROWS[i].opcode;
      r.key      = DIR_ROWS[i].key;
      r.owner_id = DIR_ROWS[i].owner;
      offer_request(r, DIR_ROWS[i].typed, DIR_ROWS[i].rsp);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      offer_request(pick_request((n / 150) % 3), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (checked_n < offered_n) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("Requests: %0d (ok %0d, not found %0d, duplicate %0d, full %0d).",
             offered_n, status_seen[STS_OK], status_seen[STS_NOT_FOUND],
             status_seen[STS_DUPLICATE], status_seen[STS_FULL]);
    $display("Responses compared: %0d, peak occupancy %0d of %0d, mismatches %0d.",
             checked_n, peak_count, DEPTH, fail_n);
    if (fail_n == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
